[design/stbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants for the sorted table search block
// Table geometry, command codes, controller states and the control/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int MATCH_W     = 11;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [MATCH_W-1:0] NOT_FOUND = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KICK,
        S_PROBE,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic start;
        logic write;
        logic kick;
        logic probe;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic span_zero;
        logic next_span_zero;
        logic out_free;
    } t_dp_status;

endpackage

[design/stbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl: search sequencer
// Accepts words, starts table writes and searches, steps the search one
// probe per cycle and hands the final compare to the output register.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    output logic                o_in_ready,
    input  stbs_pkg::t_dp_status i_status,
    output stbs_pkg::t_dp_cmd    o_cmd
);
    import stbs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_SEARCH)) begin
                    n_state = S_KICK;
                end
            end
            S_KICK: begin
                n_state = i_status.span_zero ? S_FINAL : S_PROBE;
            end
            S_PROBE: begin
                n_state = i_status.next_span_zero ? S_FINAL : S_PROBE;
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.start  = accept && (i_command == CMD_SEARCH);
                o_cmd.write  = accept && (i_command == CMD_WRITE);
            end
            S_KICK: begin
                o_cmd.kick = 1'b1;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            S_FINAL: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[design/stbs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_dp: search datapath
// Key table memory, entry count register, lower-bound window registers,
// key compare and the result output register.
// ----------------------------------------------------------------------------
module stbs_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [stbs_pkg::CNT_W-1:0]             i_cfg_wdata,
    input  logic [stbs_pkg::ADDR_W-1:0]            i_entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0]      i_key_value,
    input  stbs_pkg::t_dp_cmd                      i_cmd,
    output stbs_pkg::t_dp_status                   o_status,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_found,
    output logic signed [stbs_pkg::MATCH_W-1:0]    o_match_index
);
    import stbs_pkg::*;

    logic signed [KEY_W-1:0] r_table [TABLE_DEPTH];
    logic signed [KEY_W-1:0] r_rdata;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_used;
    logic [CNT_W-1:0]        r_left;
    logic [CNT_W-1:0]        r_span;
    logic                    r_out_valid;
    logic                    r_found;
    logic [MATCH_W-1:0]      r_match_index;

    logic [CNT_W-1:0] half;
    logic             less;
    logic [CNT_W-1:0] n_left;
    logic [CNT_W-1:0] n_span;
    logic [CNT_W-1:0] tgt_left;
    logic [CNT_W-1:0] tgt_span;
    logic [CNT_W-1:0] rd_addr;
    logic             rd_en;
    logic             hit;
    logic             out_free;

    // one lower-bound step from the probe just read
    assign half   = r_span >> 1;
    assign less   = r_rdata < r_key;
    assign n_left = less ? (r_left + half + CNT_W'(1)) : r_left;
    assign n_span = less ? (r_span - half - CNT_W'(1)) : half;

    // next read: midpoint while the window is open, else the final entry
    assign tgt_left = i_cmd.kick ? r_left : n_left;
    assign tgt_span = i_cmd.kick ? r_span : n_span;
    assign rd_addr  = (tgt_span != '0) ? (tgt_left + (tgt_span >> 1)) : tgt_left;
    assign rd_en    = (i_cmd.kick || i_cmd.probe)
                      && ((tgt_span != '0) || (tgt_left < r_used));

    assign hit      = (r_left < r_used) && (r_rdata == r_key);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.span_zero      = (r_span == '0);
    assign o_status.next_span_zero = (n_span == '0);
    assign o_status.out_free       = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_table[i_entry_index] <= i_key_value;
        end
        if (rd_en) begin
            r_rdata <= r_table[rd_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cfg_we) begin
            r_used <= (i_cfg_wdata > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= i_key_value;
            r_left <= '0;
            r_span <= r_used;
        end else if (i_cmd.probe) begin
            r_left <= n_left;
            r_span <= n_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found       <= hit;
            r_match_index <= hit ? MATCH_W'(r_left) : NOT_FOUND;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = $signed(r_match_index);

endmodule

[design/sorted_table_binary_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top: exact-match search in a sorted key table
// Input channel (i_in_valid / o_in_ready) carries a command, a table index
// and a signed 32-bit key. A write word stores the key at the index and
// gives no result. A search word runs a lower-bound binary search over the
// first entry_count entries and gives one result word on the output channel
// (o_out_valid / i_out_ready): found and the index of the first equal entry,
// or -1. After a search is accepted, a kick state reads the first probe,
// probe states then take one table read per level on the single memory read
// port, and a final state loads the compare into the output register.
// Searches do not overlap; writes are taken back to back. The result sits in
// an output register, so the next word is accepted while a result waits; a
// search that ends while the output is stalled holds until the receiver
// takes the waiting result. entry_count is written through i_cfg_we /
// i_cfg_wdata and saturates at the table depth; the user must write it only
// while idle, and the block itself does not enforce this.
// Reset clears entry_count, the sequencer and the output valid; table
// contents are undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stbs_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [stbs_pkg::ADDR_W-1:0]         i_entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0]   i_key_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic signed [stbs_pkg::MATCH_W-1:0] o_match_index
);
    import stbs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stbs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_match_index (o_match_index)
    );

    // a found result carries a real table index
    a_found_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> !o_match_index[MATCH_W-1])
        else $error("found result with negative index");

    // a miss always reports all ones
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_match_index == $signed(NOT_FOUND)))
        else $error("miss result with bad index");

    // a search holds off the next word in the cycle after it is accepted
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_SEARCH) |=> !o_in_ready)
        else $error("input accepted during search");

    // writes never start a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == CMD_WRITE) && !o_out_valid
        |=> !o_out_valid)
        else $error("result after table write");

endmodule

[tb/sorted_table_binary_search_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top_tb: self-checking bench for the key table
// Loads sorted key tables through the input channel, sets entry_count at
// its extremes and at many other sizes, and runs exact-match searches. A
// short directed plan covers the empty table, the smallest and largest keys,
// duplicates, a key above every entry and an unsorted table. Random phases
// follow with hits, near misses, random keys and stray writes. Every result
// word is compared with a hand-written expectation or a lower-bound search
// model kept in the bench; both channels idle and stall at random outside
// phases five to seven, and the output is held off for a long stretch once.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top_tb;

    import stbs_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 500000;
    localparam int TARGET_WORDS = 1900;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 16;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic                      found;
        logic signed [MATCH_W-1:0] match_index;
    } t_lookup_result;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic                    cmd;
        logic [ADDR_W-1:0]       entry;
        logic signed [KEY_W-1:0] value;
        logic                    typed;
        t_lookup_result          result;
    } t_plan_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CNT_W-1:0]            i_cfg_wdata;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_command;
    logic [ADDR_W-1:0]           i_entry_index;
    logic signed [KEY_W-1:0]     i_key_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_found;
    logic signed [MATCH_W-1:0]   o_match_index;

    logic signed [KEY_W-1:0]     key_mirror [TABLE_DEPTH];
    logic [CNT_W-1:0]            table_count;
    t_lookup_result              pending_results [$];

    bit                          gaps_on;
    bit                          hold_req;
    int                          n_errors;
    int                          n_writes;
    int                          n_searches;
    int                          n_checked;
    int                          n_settings;
    int                          n_cycles;

    t_plan_row directed_plan [0:22] = '{
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd0,   1'b1, '{1'b0, NOT_FOUND}},
        '{ROW_WORD, CMD_WRITE,  10'd0,    KEY_MIN,  1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_WRITE,  10'd1,    -32'sd5,  1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_WRITE,  10'd2,    32'sd7,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_WRITE,  10'd3,    32'sd7,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_WRITE,  10'd4,    KEY_MAX,  1'b0, '{1'b0, 11'sd0}},
        '{ROW_CFG,  CMD_WRITE,  10'd0,    32'sd5,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd1023, KEY_MIN,  1'b1, '{1'b1, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    KEY_MAX,  1'b1, '{1'b1, 11'sd4}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd7,   1'b1, '{1'b1, 11'sd2}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd6,   1'b1, '{1'b0, NOT_FOUND}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    -32'sd5,  1'b1, '{1'b1, 11'sd1}},
        '{ROW_CFG,  CMD_WRITE,  10'd0,    32'sd4,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    KEY_MAX,  1'b1, '{1'b0, NOT_FOUND}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd8,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_WRITE,  10'd1023, -32'sd1,  1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_WRITE,  10'd0,    32'sd100, 1'b0, '{1'b0, 11'sd0}},
        '{ROW_CFG,  CMD_WRITE,  10'd0,    32'sd3,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    -32'sd5,  1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd100, 1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd7,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_CFG,  CMD_WRITE,  10'd0,    32'sd0,   1'b0, '{1'b0, 11'sd0}},
        '{ROW_WORD, CMD_SEARCH, 10'd0,    32'sd100, 1'b1, '{1'b0, NOT_FOUND}}
    };

    sorted_table_binary_search_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_match_index (o_match_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // lower-bound search over the entries in use, count saturated at the depth
    function automatic t_lookup_result lower_bound_lookup(input logic signed [KEY_W-1:0] key);
        int             used;
        int             left;
        int             span;
        int             half;
        t_lookup_result res;
        used = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        left = 0;
        span = used;
        while (span > 0) begin
            half = span / 2;
            if (key_mirror[left + half] < key) begin
                left = left + half + 1;
                span = span - half - 1;
            end else begin
                span = half;
            end
        end
        res.found       = 1'b0;
        res.match_index = NOT_FOUND;
        if (left < used) begin
            if (key_mirror[left] == key) begin
                res.found       = 1'b1;
                res.match_index = left[MATCH_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] entry,
                             input logic signed [KEY_W-1:0] key, input logic typed,
                             input t_lookup_result typed_result);
        while (gaps_on && $urandom_range(99) < 17) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_command     = cmd;
        i_entry_index = entry;
        i_key_value   = key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cmd == CMD_WRITE) begin
            key_mirror[entry] = key;
            n_writes++;
        end else begin
            pending_results.push_back(typed ? typed_result : lower_bound_lookup(key));
            n_searches++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_and_set_count(input logic [CNT_W-1:0] count);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = count;
        table_count = count;
        n_settings++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ascending keys from start, with duplicates, clipped at the largest key
    task automatic load_sorted(input int count, input longint start, input int step_max);
        longint v;
        v = start;
        for (int i = 0; i < count; i++) begin
            send_word(CMD_WRITE, i[ADDR_W-1:0], v[KEY_W-1:0], 1'b0, '0);
            if ($urandom_range(4) != 0) v = v + $urandom_range(step_max);
            if (v > longint'(KEY_MAX)) v = longint'(KEY_MAX);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_ready = !(gaps_on && $urandom_range(99) < 17);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no search pending: found %0d match_index %0d",
                       o_found, o_match_index);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    n_errors++;
                end
                if (o_match_index !== want.match_index) begin
                    $error("match_index: expected %0d, got %0d",
                           want.match_index, o_match_index);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_cycles = 0;
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results still pending",
                         n_cycles, pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int                      phase;
        int                      count;
        int                      used;
        int                      n_lookups;
        int                      pick;
        logic signed [KEY_W-1:0] key;
        longint                  start;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_command     = CMD_WRITE;
        i_entry_index = '0;
        i_key_value   = '0;
        table_count   = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        n_errors      = 0;
        n_writes      = 0;
        n_searches    = 0;
        n_checked     = 0;
        n_settings    = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_CFG) begin
                drain_and_set_count(directed_plan[r].value[CNT_W-1:0]);
            end else begin
                send_word(directed_plan[r].cmd, directed_plan[r].entry,
                          directed_plan[r].value, directed_plan[r].typed,
                          directed_plan[r].result);
            end
        end

        // whole table, sorted across the full key range
        load_sorted(TABLE_DEPTH, longint'(KEY_MIN), 1 << 23);

        phase = 0;
        while (n_writes + n_searches < TARGET_WORDS) begin
            case (phase)
                0: count = 2047;
                1: count = TABLE_DEPTH;
                2: count = TABLE_DEPTH - 1;
                default: begin
                    pick = $urandom_range(99);
                    if (pick < 15) count = $urandom_range(2047);
                    else if (pick < 25) count = $urandom_range(1);
                    else count = $urandom_range(64, 2);
                end
            endcase
            gaps_on = (phase < 5 || phase > 7);
            drain_and_set_count(count[CNT_W-1:0]);
            used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            if (used > 0 && used <= 64) begin
                start = ($urandom_range(9) == 0) ? longint'(KEY_MIN)
                                                 : longint'($signed($urandom()));
                case ($urandom_range(2))
                    0: load_sorted(used, start, 3);
                    1: load_sorted(used, start, 1000);
                    default: load_sorted(used, start, 1 << 24);
                endcase
            end
            if (phase == 4) hold_req = 1'b1;
            n_lookups = (used > 64) ? 60 : 30;
            repeat (n_lookups) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    // stray write, may leave the table unsorted
                    send_word(CMD_WRITE, ADDR_W'($urandom()), $urandom(), 1'b0, '0);
                end else begin
                    if (used > 0 && pick < 60) key = key_mirror[$urandom_range(used - 1)];
                    else key = $urandom();
                    if (used > 0 && pick >= 60 && pick < 80) begin
                        key = key_mirror[$urandom_range(used - 1)];
                        key = ($urandom_range(1) == 0) ? key + 32'sd1 : key - 32'sd1;
                    end
                    send_word(CMD_SEARCH, ADDR_W'($urandom()), key, 1'b0, '0);
                end
            end
            phase++;
        end

        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("covered %0d table writes and %0d searches over %0d entry_count settings,",
                 n_writes, n_searches, n_settings);
        $display("%0d result words compared, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
design/stbs_pkg.sv
design/stbs_ctrl.sv
design/stbs_dp.sv
design/sorted_table_binary_search_top.sv
tb/sorted_table_binary_search_top_tb.sv
